[hw/rtl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator package
// Shared constants, codes, command struct and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  // Pool geometry.
  localparam int unsigned MaxBlocks  = 256;
  localparam int unsigned AlignBytes = 8;   // power of two
  localparam int unsigned IdxW       = 8;
  localparam int unsigned PtrW       = $clog2(MaxBlocks) + 1;
  localparam int unsigned CountW     = 9;
  localparam int unsigned BytesW     = 13;
  localparam int unsigned SizeW      = BytesW + 1;
  localparam int unsigned OffsetW    = 20;
  localparam int unsigned ProdW      = PtrW + SizeW;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StatusW    = 2;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CfgBlockCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBytes = 1'd1;
  localparam logic [CountW-1:0]  BlockCountRst = 9'd256;
  localparam logic [BytesW-1:0]  BlockBytesRst = 13'd8;

  // Request kinds.
  localparam logic [KindW-1:0] KindAlloc  = 2'd0;
  localparam logic [KindW-1:0] KindFree   = 2'd1;
  localparam logic [KindW-1:0] KindReinit = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

  // End-of-list marker for the stack head.
  localparam logic [PtrW-1:0] EndMarker = PtrW'(MaxBlocks);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and launch the link read
    logic commit;  // update the free list and load the result register
  } fba_cmd_t;

  // Block size rounded up to the alignment.
  function automatic logic [SizeW-1:0] rounded_size(input logic [BytesW-1:0] bytes);
    logic [SizeW-1:0] sum;
    sum = {1'b0, bytes} + SizeW'(AlignBytes - 1);
    return sum & ~SizeW'(AlignBytes - 1);
  endfunction

  // Block count limited to the pool size.
  function automatic logic [PtrW-1:0] eff_count(input logic [CountW-1:0] count);
    logic [PtrW-1:0] res;
    if (PtrW'(count) > PtrW'(MaxBlocks)) begin
      res = PtrW'(MaxBlocks);
    end else begin
      res = PtrW'(count);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fba_if.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface fba_req_if
  import fba_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdxW-1:0]  block_index;

  modport source (output valid, output kind, output block_index, input ready);
  modport sink   (input valid, input kind, input block_index, output ready);
endinterface

interface fba_rsp_if
  import fba_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [IdxW-1:0]    given_index;
  logic [OffsetW-1:0] byte_offset;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  free_count;

  modport source (output valid, output granted, output given_index, output byte_offset,
                  output status, output free_count, input ready);
  modport sink   (input valid, input granted, input given_index, input byte_offset,
                  input status, input free_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/fba_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/fba_ctrl.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator controller
// Two-state sequencer and response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ctrl
  import fba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output fba_cmd_t  cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic rsp_valid_q, rsp_valid_d;

  // Accept in idle; commit once the result register is free or being drained.
  always_comb begin
    req_ready_o  = (state_q == StIdle);
    cmd_o.load   = req_valid_i && req_ready_o;
    cmd_o.commit = (state_q == StExec) && (!rsp_valid_q || rsp_ready_i);
  end

  // Next state and response valid.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (cmd_o.commit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  // An accepted request always enters execution in the following cycle.
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StExec))
    else $error("accepted request did not enter execution");

  // A commit never overwrites a result that is still waiting.
  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register overwritten");

  // A new result only appears right after an execution cycle.
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == StExec))
    else $error("result appeared without execution");

  // Requests are never taken while one is in execution.
  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> !cmd_o.load)
    else $error("request accepted during execution");

endmodule

`default_nettype wire

[hw/rtl/fba_dp.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator datapath
// Free-list state, link memory, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_dp
  import fba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fba_cmd_t            cmd_i,
  input  wire logic [KindW-1:0]    req_kind_i,
  input  wire logic [IdxW-1:0]     req_index_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     granted_o,
  output logic      [IdxW-1:0]     given_index_o,
  output logic      [OffsetW-1:0]  byte_offset_o,
  output logic      [StatusW-1:0]  status_o,
  output logic      [CountW-1:0]   free_count_o
);

  // Configuration registers.
  logic [CountW-1:0] block_count_q;
  logic [BytesW-1:0] block_bytes_q;

  // Free-list state.
  logic [PtrW-1:0]   head_q, head_d;
  logic [CountW-1:0] stacked_q, stacked_d;
  logic [PtrW-1:0]   fill_q, fill_d;

  // Captured request.
  logic [KindW-1:0]  kind_q;
  logic [IdxW-1:0]   index_q;

  // Result registers.
  logic               granted_q;
  logic [IdxW-1:0]    given_q;
  logic [OffsetW-1:0] offset_q;
  logic [StatusW-1:0] status_q;
  logic [CountW-1:0]  free_q;

  // Execution-cycle signals.
  logic [PtrW-1:0]    eff;
  logic [SizeW-1:0]   rsize;
  logic [PtrW-1:0]    link_rdata;
  logic               link_we;
  logic               granted_d;
  logic [PtrW-1:0]    blk;
  logic [StatusW-1:0] status_d;
  logic [PtrW-1:0]    unfilled;
  logic [CountW:0]    total;
  logic [CountW-1:0]  free_d;
  logic [ProdW-1:0]   product;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BlockCountRst;
      block_bytes_q <= BlockBytesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBlockCount: block_count_q <= cfg_data_i[CountW-1:0];
        CfgBlockBytes: block_bytes_q <= cfg_data_i[BytesW-1:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_kind_i;
      index_q <= req_index_i;
    end
  end

  // Link memory: read the head's link on accept, write the pushed link on commit.
  fba_ram #(
    .Width (PtrW),
    .Depth (MaxBlocks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (index_q),
    .wdata_i (head_q),
    .re_i    (cmd_i.load),
    .raddr_i (head_q[PtrW-2:0]),
    .rdata_o (link_rdata)
  );

  assign eff   = eff_count(block_count_q);
  assign rsize = rounded_size(block_bytes_q);

  // Free-list update for the captured request.
  always_comb begin
    head_d    = head_q;
    stacked_d = stacked_q;
    fill_d    = fill_q;
    granted_d = 1'b0;
    blk       = '0;
    status_d  = StatusOk;
    link_we   = 1'b0;
    case (kind_q)
      KindAlloc: begin
        if (head_q < EndMarker) begin
          blk       = head_q;
          head_d    = link_rdata;
          granted_d = 1'b1;
          if (stacked_q != '0) begin
            stacked_d = stacked_q - CountW'(1);
          end
        end else if (fill_q < eff) begin
          blk       = fill_q;
          fill_d    = fill_q + PtrW'(1);
          granted_d = 1'b1;
        end else begin
          status_d = StatusEmpty;
        end
      end
      KindFree: begin
        if (PtrW'(index_q) >= eff) begin
          status_d = StatusRange;
        end else begin
          link_we = cmd_i.commit;
          head_d  = PtrW'(index_q);
          if (stacked_q < CountW'(MaxBlocks)) begin
            stacked_d = stacked_q + CountW'(1);
          end
        end
      end
      KindReinit: begin
        head_d    = EndMarker;
        stacked_d = '0;
        fill_d    = '0;
      end
      default: ;
    endcase
  end

  // Free count after the update, saturated at the pool size.
  always_comb begin
    unfilled = (eff > fill_d) ? (eff - fill_d) : '0;
    total    = {1'b0, stacked_d} + (CountW + 1)'(unfilled);
    if (total > (CountW + 1)'(MaxBlocks)) begin
      free_d = CountW'(MaxBlocks);
    end else begin
      free_d = total[CountW-1:0];
    end
  end

  // Byte offset of the granted block.
  assign product = granted_d ? (ProdW'(blk) * ProdW'(rsize)) : '0;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= EndMarker;
      stacked_q <= '0;
      fill_q    <= '0;
    end else if (cmd_i.commit) begin
      head_q    <= head_d;
      stacked_q <= stacked_d;
      fill_q    <= fill_d;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      given_q   <= blk[IdxW-1:0];
      offset_q  <= product[OffsetW-1:0];
      status_q  <= status_d;
      free_q    <= free_d;
    end
  end

  assign granted_o     = granted_q;
  assign given_index_o = given_q;
  assign byte_offset_o = offset_q;
  assign status_o      = status_q;
  assign free_count_o  = free_q;

  // A non-empty stack always has a head inside the pool.
  a_stack_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stacked_q != '0) |-> (head_q < EndMarker))
    else $error("stacked blocks without a valid head");

  // Only a valid free writes the link memory.
  a_link_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_we |-> (cmd_i.commit && (kind_q == KindFree) && (status_d == StatusOk)))
    else $error("unexpected link write");

  // The fill pointer never passes the pool size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PtrW'(MaxBlocks))
    else $error("fill pointer beyond pool");

endmodule

`default_nettype wire

[hw/rtl/fixed_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator unit
// Pool of equal blocks with a LIFO free list and lazy fill pointer.
// ----------------------------------------------------------------------------
// An accepted request enters the execution state and commits there once the
// result register is free or being drained; the commit loads the result
// register. No new request is taken until the last one commits. The link
// memory is read on acceptance and the head updates on commit.
// The result register lets a new request be taken while a result waits.
// Reset: asynchronous, active low; free list empty, fill pointer zero,
// block_count 256, block_bytes 8. The link memory is not cleared.
`default_nettype none

module fixed_block_allocator_unit
  import fba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fba_req_if.sink                  req_i,
  fba_rsp_if.source                rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  fba_cmd_t cmd;

  // Sequencer.
  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Free-list datapath.
  fba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_kind_i    (req_i.kind),
    .req_index_i   (req_i.block_index),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .granted_o     (rsp_o.granted),
    .given_index_o (rsp_o.given_index),
    .byte_offset_o (rsp_o.byte_offset),
    .status_o      (rsp_o.status),
    .free_count_o  (rsp_o.free_count)
  );

endmodule

`default_nettype wire

[verif/fixed_block_allocator_unit_test.sv]
// ----------------------------------------------------------------------------
// Fixed block allocator unit testbench
// Drives allocate, free and reinitialize requests through the request channel
// and writes the pool registers between phases. A scoreboard keeps its own copy
// of the free list, fill pointer and registers, works out each response and
// compares every field of every response in order. Both channels stall at
// random for most of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_block_allocator_unit_test;
  import fba_pkg::*;

  // The request kind that the block leaves unused.
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic               granted;
    logic [IdxW-1:0]    given_index;
    logic [OffsetW-1:0] byte_offset;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  free_count;
  } alloc_result_t;

  // Scoreboard: shadow free list and the queue of responses still owed.
  class pool_scoreboard;
    logic [PtrW-1:0]   link_mem [MaxBlocks];
    logic [PtrW-1:0]   head;
    logic [CountW-1:0] stacked;
    logic [CountW-1:0] fill;
    logic [CountW-1:0] count_reg;
    logic [BytesW-1:0] bytes_reg;
    alloc_result_t     owed[$];
    int unsigned       errors;

    function void clear();
      head      = EndMarker;
      stacked   = '0;
      fill      = '0;
      count_reg = BlockCountRst;
      bytes_reg = BlockBytesRst;
      errors    = 0;
      owed.delete();
    endfunction

    function int unsigned pool_blocks();
      return (count_reg > MaxBlocks) ? MaxBlocks : count_reg;
    endfunction

    function int unsigned free_blocks();
      int unsigned unfilled;
      int unsigned total;
      unfilled = (pool_blocks() > fill) ? pool_blocks() - fill : 0;
      total = stacked + unfilled;
      return (total > MaxBlocks) ? MaxBlocks : total;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgBlockCount) begin
        count_reg = data[CountW-1:0];
      end else if (idx == CfgBlockBytes) begin
        bytes_reg = data[BytesW-1:0];
      end
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function alloc_result_t note_request(logic [KindW-1:0] kind, logic [IdxW-1:0] idx);
      alloc_result_t r;
      logic [PtrW-1:0] blk;
      bit have;
      int unsigned size;
      r = '0;
      blk = '0;
      have = 1'b0;
      case (kind)
        KindAlloc: begin
          // Returned blocks are reused first, then untouched ones in order.
          if (head < MaxBlocks) begin
            blk = head;
            head = link_mem[blk];
            if (stacked > 0) stacked--;
            have = 1'b1;
          end else if (fill < pool_blocks()) begin
            blk = fill;
            fill++;
            have = 1'b1;
          end
          if (have) begin
            size = ((bytes_reg + AlignBytes - 1) / AlignBytes) * AlignBytes;
            r.granted = 1'b1;
            r.given_index = blk[IdxW-1:0];
            r.byte_offset = OffsetW'(blk * size);
          end else begin
            r.status = StatusEmpty;
          end
        end
        KindFree: begin
          if (idx >= pool_blocks()) begin
            r.status = StatusRange;
          end else begin
            link_mem[idx] = head;
            head = PtrW'(idx);
            if (stacked < MaxBlocks) stacked++;
          end
        end
        KindReinit: begin
          head = EndMarker;
          stacked = '0;
          fill = '0;
        end
        default: ;
      endcase
      r.free_count = CountW'(free_blocks());
      owed.push_back(r);
      return r;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_response(alloc_result_t got);
      alloc_result_t exp;
      if (owed.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        exp = owed.pop_front();
        if (got.granted !== exp.granted)
          report($sformatf("granted %0h, expected %0h", got.granted, exp.granted));
        if (got.given_index !== exp.given_index)
          report($sformatf("given_index %0h, expected %0h", got.given_index, exp.given_index));
        if (got.byte_offset !== exp.byte_offset)
          report($sformatf("byte_offset %0h, expected %0h", got.byte_offset, exp.byte_offset));
        if (got.status !== exp.status)
          report($sformatf("status %0h, expected %0h", got.status, exp.status));
        if (got.free_count !== exp.free_count)
          report($sformatf("free_count %0h, expected %0h", got.free_count, exp.free_count));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  bit                  idling;
  logic [IdxW-1:0]     held[$];
  pool_scoreboard      sb;

  fba_req_if req ();
  fba_rsp_if rsp ();

  fixed_block_allocator_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sends one request, waits for it to be taken and returns the predicted response.
  task automatic push_request(input logic [KindW-1:0] kind, input logic [IdxW-1:0] idx,
                              output alloc_result_t r);
    int unsigned gap;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    @(negedge clk);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.kind = kind;
    req.block_index = idx;
    do @(posedge clk); while (req.ready !== 1'b1);
    r = sb.note_request(kind, idx);
  endtask

  // Drops the request line and waits for every owed response plus the pipeline.
  task automatic settle();
    @(negedge clk);
    req.valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly allocations and frees of blocks really held, with some noise mixed in.
  task automatic run_phase(input logic [CountW-1:0] count, input logic [BytesW-1:0] bytes,
                           input int items, input int alloc_pct, input int reinit_pct);
    alloc_result_t r;
    logic [KindW-1:0] kind;
    logic [IdxW-1:0] idx;
    int roll;
    int slot;
    settle();
    cfg_write(CfgBlockCount, CfgDataW'(count));
    cfg_write(CfgBlockBytes, bytes);
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      idx = IdxW'($urandom_range(0, 255));
      if (roll < alloc_pct) begin
        kind = KindAlloc;
      end else if (roll < alloc_pct + reinit_pct) begin
        kind = KindReinit;
      end else if (roll >= 98) begin
        kind = KindUnused;
      end else begin
        kind = KindFree;
        if (held.size() > 0 && $urandom_range(0, 4) != 0) begin
          slot = $urandom_range(0, held.size() - 1);
          idx = held[slot];
          held.delete(slot);
        end
      end
      push_request(kind, idx, r);
      if (kind == KindReinit) begin
        held.delete();
      end else if (r.granted) begin
        held.push_back(r.given_index);
      end
    end
  endtask

  // Response side: ready drops for random bursts while idling is on.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 4) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      rsp.ready = 1'b1;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    alloc_result_t got;
    if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.granted = rsp.granted;
      got.given_index = rsp.given_index;
      got.byte_offset = rsp.byte_offset;
      got.status = rsp.status;
      got.free_count = rsp.free_count;
      sb.check_response(got);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int unsigned stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence.
  initial begin
    alloc_result_t r;
    sb = new;
    sb.clear();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.kind = KindAlloc;
    req.block_index = '0;
    idling = 1'b1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a three-block pool with a size that needs rounding.
    cfg_write(CfgBlockCount, CfgDataW'(3));
    cfg_write(CfgBlockBytes, CfgDataW'(13));
    repeat (3) push_request(KindAlloc, 8'd0, r);
    push_request(KindAlloc, 8'd255, r);   // pool exhausted
    push_request(KindFree, 8'd255, r);    // index far out of range
    push_request(KindFree, 8'd3, r);      // index just past the pool
    push_request(KindFree, 8'd0, r);
    push_request(KindFree, 8'd2, r);
    repeat (2) push_request(KindAlloc, 8'd0, r);
    push_request(KindAlloc, 8'd0, r);     // empty again
    push_request(KindFree, 8'd1, r);
    push_request(KindFree, 8'd1, r);      // double free goes unnoticed
    repeat (3) push_request(KindAlloc, 8'd0, r);
    push_request(KindUnused, 8'd170, r);
    push_request(KindReinit, 8'd85, r);
    push_request(KindAlloc, 8'd0, r);
    push_request(KindFree, 8'd0, r);

    // Random phases over the register extremes; no reinitialize between them,
    // so count changes land on a running pool.
    run_phase(9'd256, 13'd8191, 300, 96, 0);
    run_phase(9'd7, 13'd0, 80, 50, 3);
    run_phase(9'd1, 13'd1, 40, 50, 3);
    run_phase(9'd0, 13'd4096, 20, 50, 5);
    run_phase(9'd511, BytesW'($urandom_range(0, 8191)), 60, 60, 3);
    idling = 1'b0;
    run_phase(CountW'($urandom_range(1, 256)), BytesW'($urandom_range(1, 4096)), 100, 50, 4);

    settle();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fba_pkg.sv
hw/rtl/fba_if.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_ctrl.sv
hw/rtl/fba_dp.sv
hw/rtl/fixed_block_allocator_unit.sv
verif/fixed_block_allocator_unit_test.sv
